>>> src/rgbyuv_pkg.sv
// Shared constants and types for the RGB24 to YUV 4:2:0 converter.
package rgbyuv_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int SIZE_W = 13;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  typedef enum logic [1:0] {
    CHROMA_NONE = 2'd0,
    CHROMA_U    = 2'd1,
    CHROMA_V    = 2'd2
  } chroma_kind_t;

  // Last valid position for a programmed size: 0 acts as 1, oversize clamps.
  function automatic logic [SIZE_W-1:0] last_pos(input logic [SIZE_W-1:0] size,
                                                  input int max_size);
    logic [SIZE_W-1:0] res;
    if (size == '0) begin
      res = '0;
    end else if (32'(size) > max_size) begin
      res = SIZE_W'(max_size - 1);
    end else begin
      res = size - SIZE_W'(1);
    end
    return res;
  endfunction

endpackage

>>> src/rgb24_to_yuv420_converter_unit.sv
// Top level of the RGB24 to YUV 4:2:0 pixel-stream converter.
//
// Pixels arrive in raster order on the input channel (in_valid/in_stall,
// red/green/blue), one item per pixel. Each pixel gives one result item on
// the output channel (out_valid/out_stall): luma, and at even columns a
// chroma sample, U on even rows and V on odd rows. frame_end marks the last
// pixel of the frame.
// The frame size sits in two registers written over the cfg channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data); cfg_ready is always high and
// unknown indexes are dropped. Writes do not touch the position counters.
// Timing: an accepted pixel lands in an input register, the color products
// are formed between it and the result register, which drives out_valid.
// One pixel per cycle is sustained while the receiver does not stall.
// Reset clears the position to the first pixel, empties both stages and
// loads 640x480. When the receiver stalls, the result holds; one more pixel
// can still enter the input register before in_stall is raised.
module rgb24_to_yuv420_converter_unit
  import rgbyuv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        luma,
  output logic [1:0]        chroma_kind,
  output logic [7:0]        chroma,
  output logic              frame_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;

  logic              s1_valid;
  logic [7:0]        s1_red;
  logic [7:0]        s1_green;
  logic [7:0]        s1_blue;
  logic              s1_even_col;
  logic              s1_even_row;
  logic              s1_frame_end;

  logic              advance;
  logic              accept;
  logic              last_col;
  logic              last_row;

  logic [16:0]        luma_sum;
  logic signed [17:0] u_sum;
  logic signed [17:0] v_sum;
  logic signed [17:0] rs;
  logic signed [17:0] gs;
  logic signed [17:0] bs;
  logic [7:0]         luma_next;
  logic [7:0]         chroma_next;
  chroma_kind_t       kind_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipe moves when the result register is free or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  assign last_col = {1'b0, column_count} >= last_pos(frame_width, MAX_WIDTH);
  assign last_row = {1'b0, row_count} >= last_pos(frame_height, MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red       <= red;
      s1_green     <= green;
      s1_blue      <= blue;
      s1_even_col  <= !column_count[0];
      s1_even_row  <= !row_count[0];
      s1_frame_end <= last_col && last_row;
    end
  end

  // Constant multiplies; the low byte of each sum's >>8 is bits [15:8].
  always_comb begin
    rs = $signed({10'd0, s1_red});
    gs = $signed({10'd0, s1_green});
    bs = $signed({10'd0, s1_blue});
    luma_sum = 17'd66 * {9'd0, s1_red} + 17'd129 * {9'd0, s1_green}
             + 17'd25 * {9'd0, s1_blue} + 17'd128;
    u_sum = 18'sd112 * bs - 18'sd38 * rs - 18'sd74 * gs + 18'sd128;
    v_sum = 18'sd112 * rs - 18'sd94 * gs - 18'sd18 * bs + 18'sd128;
    luma_next = luma_sum[15:8] + 8'd16;
    if (!s1_even_col) begin
      kind_next   = CHROMA_NONE;
      chroma_next = 8'd0;
    end else if (s1_even_row) begin
      kind_next   = CHROMA_U;
      chroma_next = u_sum[15:8] + 8'd128;
    end else begin
      kind_next   = CHROMA_V;
      chroma_next = v_sum[15:8] + 8'd128;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      luma        <= luma_next;
      chroma_kind <= kind_next;
      chroma      <= chroma_next;
      frame_end   <= s1_frame_end;
    end
  end

endmodule
